// ===== rtl/ads_pkg.sv =====
package ads_pkg;

	localparam int NUM_LANES      = 4;
	localparam int DATA_WIDTH_DEF = 48;
	localparam int FRAC_BITS      = 24;
	localparam int CFG_WIDTH      = 47;
	localparam int ACT_WIDTH      = 3;
	localparam int SAT_WIDTH      = 64;
	localparam int MUL_CHUNK      = 16;
	localparam int LANE_W         = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
	localparam int CFG_IDX_WIDTH  = $clog2(NUM_LANES + 3);

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_STEP    = CFG_IDX_WIDTH'(0);
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_STEP_SQ = CFG_IDX_WIDTH'(1);
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_DISP_BASE   = CFG_IDX_WIDTH'(2);
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACTIVE      = CFG_IDX_WIDTH'(2 + NUM_LANES);

	localparam logic [CFG_WIDTH-1:0] Q_ONE        = CFG_WIDTH'(1) << FRAC_BITS;
	localparam logic [ACT_WIDTH-1:0] ACTIVE_RESET = ACT_WIDTH'(NUM_LANES);

	typedef enum logic [1:0] {
		KIND_INLET    = 2'd0,
		KIND_INTERIOR = 2'd1,
		KIND_OUTLET   = 2'd2
	} ads_kind_t;

	typedef enum logic [2:0] {
		OP_VC_NEW,
		OP_VC_OLD,
		OP_ADV,
		OP_D2,
		OP_DISP
	} ads_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_LANE,
		S_PREP,
		S_LOAD,
		S_START,
		S_WAIT,
		S_FIN1,
		S_FIN2,
		S_EMIT,
		S_UPDATE
	} ads_state_t;

	typedef struct packed {
		logic              capture;
		logic              shift;
		logic              outlet;
		logic [LANE_W-1:0] lane;
		ads_op_t           op;
		logic              prep;
		logic              load_ops;
		logic              mul_start;
		logic              fin1;
		logic              fin2;
		logic              lane_zero;
		logic              emit;
		logic              emit_zero;
		logic              emit_last;
		ads_kind_t         emit_kind;
	} ads_cmd_t;

	typedef struct packed {
		logic last;
		logic lane_active;
		logic mul_done;
		logic out_free;
	} ads_sts_t;

endpackage

// ===== rtl/advection_dispersion_stencil_top.sv =====
// Channel   Handshake                Payload
// node      node_valid / node_stall  velocity, conc_comp0..3, sink_comp0..3, last_point
// deriv     deriv_valid / deriv_stall deriv_comp0..3, node_kind, run_last
// config    cfg_write                cfg_index, cfg_data
//
// One item at a time: node_stall is low only while the controller is idle. Products share
// one multiplier that takes a 16-bit slice per cycle of its operands, which are OPW bits:
// the larger of DATA_WIDTH+2 and CFG_WIDTH+1, at most 64 (50 at the default). An active lane
// computes five products in turn, an inactive lane is set to zero without any; an item emits
// its results in turn, each computed lane by lane. A result waits in the output register under
// stall, and the next emit waits for it. Reset restores the register defaults and the node count.
module advection_dispersion_stencil_top #(
	parameter int DATA_WIDTH = ads_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ads_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [ads_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  logic                              node_valid,
	output logic                              node_stall,
	input  logic [DATA_WIDTH-1:0]             velocity,
	input  logic [DATA_WIDTH-1:0]             conc_comp0,
	input  logic [DATA_WIDTH-1:0]             conc_comp1,
	input  logic [DATA_WIDTH-1:0]             conc_comp2,
	input  logic [DATA_WIDTH-1:0]             conc_comp3,
	input  logic [DATA_WIDTH-1:0]             sink_comp0,
	input  logic [DATA_WIDTH-1:0]             sink_comp1,
	input  logic [DATA_WIDTH-1:0]             sink_comp2,
	input  logic [DATA_WIDTH-1:0]             sink_comp3,
	input  logic                              last_point,
	output logic                              deriv_valid,
	input  logic                              deriv_stall,
	output logic [DATA_WIDTH-1:0]             deriv_comp0,
	output logic [DATA_WIDTH-1:0]             deriv_comp1,
	output logic [DATA_WIDTH-1:0]             deriv_comp2,
	output logic [DATA_WIDTH-1:0]             deriv_comp3,
	output logic [1:0]                        node_kind,
	output logic                              run_last
);
	import ads_pkg::*;

	ads_cmd_t              cmd;
	ads_sts_t              sts;
	ads_kind_t             kind;
	logic [DATA_WIDTH-1:0] conc_a  [NUM_LANES];
	logic [DATA_WIDTH-1:0] sink_a  [NUM_LANES];
	logic [DATA_WIDTH-1:0] deriv_a [NUM_LANES];

	assign conc_a[0] = conc_comp0;
	assign conc_a[1] = conc_comp1;
	assign conc_a[2] = conc_comp2;
	assign conc_a[3] = conc_comp3;
	assign sink_a[0] = sink_comp0;
	assign sink_a[1] = sink_comp1;
	assign sink_a[2] = sink_comp2;
	assign sink_a[3] = sink_comp3;

	ads_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.node_valid (node_valid),
		.node_stall (node_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ads_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.node_vel    (velocity),
		.node_conc   (conc_a),
		.node_sink   (sink_a),
		.node_last   (last_point),
		.deriv_valid (deriv_valid),
		.deriv_stall (deriv_stall),
		.deriv       (deriv_a),
		.kind        (kind),
		.run_last    (run_last)
	);

	assign deriv_comp0 = deriv_a[0];
	assign deriv_comp1 = deriv_a[1];
	assign deriv_comp2 = deriv_a[2];
	assign deriv_comp3 = deriv_a[3];
	assign node_kind   = kind;

endmodule

// ===== rtl/ads_mul.sv =====
module ads_mul #(
	parameter int W   = ads_pkg::DATA_WIDTH_DEF,
	parameter int OPW = ads_pkg::DATA_WIDTH_DEF + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [OPW-1:0] a,
	input  logic [OPW-1:0] b,
	output logic [W-1:0]   y,
	output logic           done
);
	import ads_pkg::*;

	localparam int NCH = (OPW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BW  = NCH * MUL_CHUNK;
	localparam int PW  = 2 * OPW;
	localparam int CW  = $clog2(NCH + 1);
	localparam int QW  = PW + 1 - FRAC_BITS;

	localparam logic [PW:0]   HALF    = (PW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [PW:0]   HALF_M1 = HALF - (PW + 1)'(1);
	localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);
	localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

	logic [OPW-1:0]           a_mag_q;
	logic [BW-1:0]            b_sh_q;
	logic                     neg_q;
	logic [PW-1:0]            acc_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     rnd_go_q;
	logic                     clp_go_q;
	logic                     done_q;
	logic [PW:0]              sum_q;
	logic [W-1:0]             y_q;

	logic [OPW+MUL_CHUNK-1:0] pp;
	logic [QW-1:0]            q;
	logic [QW-1:0]            lim;
	logic [QW-1:0]            qc;

	function automatic logic [OPW-1:0] mag(input logic [OPW-1:0] x);
		return x[OPW-1] ? (~x + OPW'(1)) : x;
	endfunction

	assign pp  = {{MUL_CHUNK{1'b0}}, a_mag_q} * {{OPW{1'b0}}, b_sh_q[BW-1 -: MUL_CHUNK]};
	assign q   = sum_q[PW:FRAC_BITS];
	assign lim = neg_q ? LIM_NEG : LIM_POS;
	assign qc  = (q > lim) ? lim : q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rnd_go_q <= 1'b0;
			clp_go_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			rnd_go_q <= 1'b0;
			clp_go_q <= rnd_go_q;
			done_q   <= clp_go_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NCH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q   <= 1'b0;
					rnd_go_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_mag_q <= mag(a);
			b_sh_q  <= BW'(mag(b));
			neg_q   <= a[OPW-1] ^ b[OPW-1];
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q  <= {acc_q[PW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + PW'(pp);
			b_sh_q <= b_sh_q << MUL_CHUNK;
		end
		if (rnd_go_q) begin
			sum_q <= {1'b0, acc_q} + (neg_q ? HALF_M1 : HALF);
		end
		if (clp_go_q) begin
			y_q <= neg_q ? (~qc[W-1:0] + W'(1)) : qc[W-1:0];
		end
	end

	assign y    = y_q;
	assign done = done_q;

endmodule

// ===== rtl/ads_datapath.sv =====
module ads_datapath #(
	parameter int DATA_WIDTH = ads_pkg::DATA_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ads_pkg::ads_cmd_t                  cmd,
	output ads_pkg::ads_sts_t                  sts,
	input  logic                               cfg_write,
	input  logic [ads_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [ads_pkg::CFG_WIDTH-1:0]      cfg_data,
	input  logic [DATA_WIDTH-1:0]              node_vel,
	input  logic [DATA_WIDTH-1:0]              node_conc [ads_pkg::NUM_LANES],
	input  logic [DATA_WIDTH-1:0]              node_sink [ads_pkg::NUM_LANES],
	input  logic                               node_last,
	output logic                               deriv_valid,
	input  logic                               deriv_stall,
	output logic [DATA_WIDTH-1:0]              deriv [ads_pkg::NUM_LANES],
	output ads_pkg::ads_kind_t                 kind,
	output logic                               run_last
);
	import ads_pkg::*;

	localparam int OPW0 = (DATA_WIDTH + 2 > CFG_WIDTH + 1) ? DATA_WIDTH + 2 : CFG_WIDTH + 1;
	localparam int OPW  = (OPW0 > SAT_WIDTH) ? SAT_WIDTH : OPW0;
	localparam int EW   = (DATA_WIDTH + 2 > OPW) ? DATA_WIDTH + 2 : OPW;

	localparam logic signed [EW-1:0] OP_MAX = (EW'(1) << (OPW - 1)) - EW'(1);
	localparam logic signed [EW-1:0] OP_MIN = ~OP_MAX;
	localparam logic signed [EW-1:0] W_MAX  = (EW'(1) << (DATA_WIDTH - 1)) - EW'(1);
	localparam logic signed [EW-1:0] W_MIN  = ~W_MAX;

	logic [CFG_WIDTH-1:0]  inv_step_q;
	logic [CFG_WIDTH-1:0]  inv_step_sq_q;
	logic [CFG_WIDTH-1:0]  disp_q [NUM_LANES];
	logic [ACT_WIDTH-1:0]  active_q;

	logic [DATA_WIDTH-1:0] in_vel_q;
	logic [DATA_WIDTH-1:0] in_conc_q [NUM_LANES];
	logic [DATA_WIDTH-1:0] in_sink_q [NUM_LANES];
	logic                  in_last_q;

	logic [DATA_WIDTH-1:0] old_vel_q;
	logic [DATA_WIDTH-1:0] old_conc_q [NUM_LANES];
	logic [DATA_WIDTH-1:0] new_vel_q;
	logic [DATA_WIDTH-1:0] new_conc_q [NUM_LANES];
	logic [DATA_WIDTH-1:0] new_sink_q [NUM_LANES];

	logic [OPW-1:0]        diff1_q;
	logic [OPW-1:0]        diff2_q;
	logic [OPW-1:0]        op_a_q;
	logic [OPW-1:0]        op_b_q;
	logic [DATA_WIDTH-1:0] m0_q;
	logic [DATA_WIDTH-1:0] m1_q;
	logic [DATA_WIDTH-1:0] adv_q;
	logic [DATA_WIDTH-1:0] d2_q;
	logic [DATA_WIDTH-1:0] dsp_q;
	logic [OPW-1:0]        t_q;
	logic [DATA_WIDTH-1:0] res_q [NUM_LANES];

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] deriv_q [NUM_LANES];
	ads_kind_t             kind_q;
	logic                  run_last_q;

	logic [DATA_WIDTH-1:0] mul_y;
	logic                  mul_done;
	logic                  out_free;

	logic [DATA_WIDTH-1:0] c_in;
	logic [DATA_WIDTH-1:0] c_new;
	logic [DATA_WIDTH-1:0] c_old;
	logic [DATA_WIDTH-1:0] sink_sel;
	logic [OPW-1:0]        diff1_d;
	logic [OPW-1:0]        diff2_d;
	logic [OPW-1:0]        op_a_d;
	logic [OPW-1:0]        op_b_d;
	logic [OPW-1:0]        fin_tmp;
	logic [DATA_WIDTH-1:0] fin_val;

	function automatic logic signed [EW-1:0] ext_w(input logic signed [DATA_WIDTH-1:0] x);
		return EW'(x);
	endfunction

	function automatic logic signed [EW-1:0] ext_o(input logic signed [OPW-1:0] x);
		return EW'(x);
	endfunction

	function automatic logic [OPW-1:0] w_to_op(input logic signed [DATA_WIDTH-1:0] x);
		return OPW'(x);
	endfunction

	function automatic logic [OPW-1:0] sat_op(input logic signed [EW-1:0] x);
		if (x > OP_MAX) begin
			return OP_MAX[OPW-1:0];
		end else if (x < OP_MIN) begin
			return OP_MIN[OPW-1:0];
		end
		return x[OPW-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_w(input logic signed [EW-1:0] x);
		if (x > W_MAX) begin
			return W_MAX[DATA_WIDTH-1:0];
		end else if (x < W_MIN) begin
			return W_MIN[DATA_WIDTH-1:0];
		end
		return x[DATA_WIDTH-1:0];
	endfunction

	ads_mul #(
		.W   (DATA_WIDTH),
		.OPW (OPW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (op_a_q),
		.b      (op_b_q),
		.y      (mul_y),
		.done   (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_step_q    <= Q_ONE;
			inv_step_sq_q <= Q_ONE;
			active_q      <= ACTIVE_RESET;
			for (int i = 0; i < NUM_LANES; i++) begin
				disp_q[i] <= '0;
			end
		end else if (cfg_write) begin
			if (cfg_index == CFG_INV_STEP) begin
				inv_step_q <= cfg_data;
			end
			if (cfg_index == CFG_INV_STEP_SQ) begin
				inv_step_sq_q <= cfg_data;
			end
			if (cfg_index == CFG_ACTIVE) begin
				active_q <= cfg_data[ACT_WIDTH-1:0];
			end
			for (int i = 0; i < NUM_LANES; i++) begin
				if (cfg_index == CFG_IDX_WIDTH'(CFG_DISP_BASE + i)) begin
					disp_q[i] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		c_in     = in_conc_q[cmd.lane];
		c_new    = new_conc_q[cmd.lane];
		c_old    = old_conc_q[cmd.lane];
		sink_sel = cmd.outlet ? in_sink_q[cmd.lane] : new_sink_q[cmd.lane];

		if (cmd.outlet) begin
			diff1_d = sat_op(ext_w(c_new) - ext_w(c_in));
			diff2_d = '0;
		end else begin
			diff1_d = sat_op(ext_w(c_in) - ext_w(c_new));
			diff2_d = sat_op(ext_w(c_new) - ext_w(c_old));
		end

		case (cmd.op)
			OP_VC_NEW: begin
				op_a_d = w_to_op(cmd.outlet ? in_vel_q : new_vel_q);
				op_b_d = w_to_op(cmd.outlet ? c_in : c_new);
			end
			OP_VC_OLD: begin
				op_a_d = w_to_op(cmd.outlet ? new_vel_q : old_vel_q);
				op_b_d = w_to_op(cmd.outlet ? c_new : c_old);
			end
			OP_ADV: begin
				op_a_d = sat_op(ext_w(m0_q) - ext_w(m1_q));
				op_b_d = OPW'(inv_step_q);
			end
			OP_D2: begin
				op_a_d = sat_op(ext_o(diff1_q) - ext_o(diff2_q));
				op_b_d = OPW'(inv_step_sq_q);
			end
			OP_DISP: begin
				op_a_d = OPW'(disp_q[cmd.lane]);
				op_b_d = w_to_op(d2_q);
			end
			default: begin
				op_a_d = '0;
				op_b_d = '0;
			end
		endcase

		fin_tmp = sat_op(ext_o(t_q) - ext_w(sink_sel));
		fin_val = sat_w(ext_o(fin_tmp));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_vel_q  <= node_vel;
			in_last_q <= node_last;
			for (int i = 0; i < NUM_LANES; i++) begin
				in_conc_q[i] <= node_conc[i];
				in_sink_q[i] <= node_sink[i];
			end
		end
		if (cmd.shift) begin
			old_vel_q <= new_vel_q;
			new_vel_q <= in_vel_q;
			for (int i = 0; i < NUM_LANES; i++) begin
				old_conc_q[i] <= new_conc_q[i];
				new_conc_q[i] <= in_conc_q[i];
				new_sink_q[i] <= in_sink_q[i];
			end
		end
		if (cmd.prep) begin
			diff1_q <= diff1_d;
			diff2_q <= diff2_d;
		end
		if (cmd.load_ops) begin
			op_a_q <= op_a_d;
			op_b_q <= op_b_d;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_VC_NEW: m0_q  <= mul_y;
				OP_VC_OLD: m1_q  <= mul_y;
				OP_ADV:    adv_q <= mul_y;
				OP_D2:     d2_q  <= mul_y;
				OP_DISP:   dsp_q <= mul_y;
				default: begin
				end
			endcase
		end
		if (cmd.fin1) begin
			t_q <= sat_op(ext_w(dsp_q) - ext_w(adv_q));
		end
		if (cmd.fin2) begin
			res_q[cmd.lane] <= fin_val;
		end else if (cmd.lane_zero) begin
			res_q[cmd.lane] <= '0;
		end
		if (cmd.emit) begin
			kind_q     <= cmd.emit_kind;
			run_last_q <= cmd.emit_last;
			for (int i = 0; i < NUM_LANES; i++) begin
				deriv_q[i] <= cmd.emit_zero ? '0 : res_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!deriv_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free        = !out_valid_q || !deriv_stall;
	assign sts.last        = in_last_q;
	assign sts.lane_active = ACT_WIDTH'(cmd.lane) < active_q;
	assign sts.mul_done    = mul_done;
	assign sts.out_free    = out_free;

	assign deriv_valid = out_valid_q;
	assign deriv       = deriv_q;
	assign kind        = kind_q;
	assign run_last    = run_last_q;

endmodule

// ===== rtl/ads_ctrl.sv =====
module ads_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              node_valid,
	output logic              node_stall,
	input  ads_pkg::ads_sts_t sts,
	output ads_pkg::ads_cmd_t cmd
);
	import ads_pkg::*;

	ads_state_t        state_q;
	ads_state_t        state_d;
	logic [1:0]        ns_q;
	logic [1:0]        ns_d;
	logic [LANE_W-1:0] lane_q;
	logic [LANE_W-1:0] lane_d;
	ads_op_t           op_q;
	ads_op_t           op_d;
	ads_kind_t         kind_q;
	ads_kind_t         kind_d;
	logic              to_outlet;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ns_q    <= '0;
			lane_q  <= '0;
			op_q    <= OP_VC_NEW;
			kind_q  <= KIND_INLET;
		end else begin
			state_q <= state_d;
			ns_q    <= ns_d;
			lane_q  <= lane_d;
			op_q    <= op_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ns_d      = ns_q;
		lane_d    = lane_q;
		op_d      = op_q;
		kind_d    = kind_q;
		to_outlet = (kind_q == KIND_INTERIOR) && sts.last;

		cmd           = '0;
		cmd.outlet    = (kind_q == KIND_OUTLET);
		cmd.lane      = lane_q;
		cmd.op        = op_q;
		cmd.emit_kind = kind_q;

		node_stall = (state_q != S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (node_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				lane_d = '0;
				if (ns_q == 2'd0) begin
					kind_d  = KIND_INLET;
					state_d = S_EMIT;
				end else if (ns_q == 2'd1) begin
					if (sts.last) begin
						kind_d  = KIND_OUTLET;
						state_d = S_LANE;
					end else begin
						state_d = S_UPDATE;
					end
				end else begin
					kind_d  = KIND_INTERIOR;
					state_d = S_LANE;
				end
			end
			S_LANE: begin
				op_d = OP_VC_NEW;
				if (sts.lane_active) begin
					state_d = S_PREP;
				end else begin
					cmd.lane_zero = 1'b1;
					if (lane_q == LANE_W'(NUM_LANES - 1)) begin
						state_d = S_EMIT;
					end else begin
						lane_d = lane_q + LANE_W'(1);
					end
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_ops = 1'b1;
				state_d      = S_START;
			end
			S_START: begin
				cmd.mul_start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (sts.mul_done) begin
					state_d = S_LOAD;
					case (op_q)
						OP_VC_NEW: op_d = OP_VC_OLD;
						OP_VC_OLD: op_d = OP_ADV;
						OP_ADV:    op_d = OP_D2;
						OP_D2:     op_d = OP_DISP;
						default:   state_d = S_FIN1;
					endcase
				end
			end
			S_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d  = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin2 = 1'b1;
				if (lane_q == LANE_W'(NUM_LANES - 1)) begin
					state_d = S_EMIT;
				end else begin
					lane_d  = lane_q + LANE_W'(1);
					state_d = S_LANE;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_zero = (kind_q == KIND_INLET);
					cmd.emit_last = !to_outlet;
					if (to_outlet) begin
						kind_d  = KIND_OUTLET;
						lane_d  = '0;
						state_d = S_LANE;
					end else begin
						state_d = S_UPDATE;
					end
				end
			end
			S_UPDATE: begin
				if (sts.last) begin
					ns_d = '0;
				end else begin
					cmd.shift = 1'b1;
					ns_d      = (ns_q == 2'd2) ? 2'd2 : ns_q + 2'd1;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import ads_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam logic [W-1:0] MAX_Q = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_Q = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_Q = W'(1) << FRAC_BITS;
	localparam logic [CFG_WIDTH-1:0] CFG_MAX = '1;
	localparam longint SAT_HI = 64'sh0000_7fff_ffff_ffff;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES = 500;
	localparam int PHASE_ITEMS = 250;
	localparam int NUM_PHASES = 8;
	localparam int TABLE_ROWS = 16;

	typedef struct packed {
		logic [W-1:0]                vel;
		logic [NUM_LANES-1:0][W-1:0] conc;
		logic [NUM_LANES-1:0][W-1:0] sink;
		logic                        last;
	} node_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][W-1:0] d;
		ads_kind_t                   kind;
		logic                        fin;
	} deriv_t;

	typedef struct packed {
		node_t      node;
		logic       typed;
		logic [1:0] typed_n;
	} drow_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]     cfg_data = '0;
	logic                     node_valid = 1'b0;
	logic                     node_stall;
	node_t                    drive_node = '0;
	logic                     deriv_valid;
	logic                     deriv_stall = 1'b0;
	logic [W-1:0]             deriv_comp0, deriv_comp1, deriv_comp2, deriv_comp3;
	logic [1:0]               node_kind;
	logic                     run_last;

	logic       row_typed = 1'b0;
	logic [1:0] row_typed_n = 2'd0;
	bit         node_taken_now = 1'b0;
	int         tx_pct = 0;
	int         rx_pct = 0;
	int         hold_req = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	int         err_count = 0;
	int         nodes_in = 0;
	int         results_seen = 0;
	int         outlets_seen = 0;
	int         settings_done = 1;

	logic [CFG_WIDTH-1:0]                step_inv = Q_ONE;
	logic [CFG_WIDTH-1:0]                step_inv_sq = Q_ONE;
	logic [NUM_LANES-1:0][CFG_WIDTH-1:0] disp_coef = '0;
	logic [ACT_WIDTH-1:0]                lanes_on = ACTIVE_RESET;
	int                                  hist_count = 0;
	longint                              prev_vel = 0;
	longint                              cur_vel = 0;
	longint                              prev_conc[NUM_LANES] = '{default: 0};
	longint                              cur_conc[NUM_LANES] = '{default: 0};
	longint                              cur_sink[NUM_LANES] = '{default: 0};

	deriv_t fresh_q[$];
	deriv_t deriv_expected_q[$];
	drow_t  dir_tab[TABLE_ROWS];

	advection_dispersion_stencil_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.node_valid(node_valid),
		.node_stall(node_stall),
		.velocity(drive_node.vel),
		.conc_comp0(drive_node.conc[0]),
		.conc_comp1(drive_node.conc[1]),
		.conc_comp2(drive_node.conc[2]),
		.conc_comp3(drive_node.conc[3]),
		.sink_comp0(drive_node.sink[0]),
		.sink_comp1(drive_node.sink[1]),
		.sink_comp2(drive_node.sink[2]),
		.sink_comp3(drive_node.sink[3]),
		.last_point(drive_node.last),
		.deriv_valid(deriv_valid),
		.deriv_stall(deriv_stall),
		.deriv_comp0(deriv_comp0),
		.deriv_comp1(deriv_comp1),
		.deriv_comp2(deriv_comp2),
		.deriv_comp3(deriv_comp3),
		.node_kind(node_kind),
		.run_last(run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat48(longint x);
		if (x > SAT_HI) return SAT_HI;
		if (x < SAT_LO) return SAT_LO;
		return x;
	endfunction

	function automatic longint sx48(logic [W-1:0] v);
		longint r;
		r = {{(64-W){v[W-1]}}, v};
		return r;
	endfunction

	// Exact product, shifted down by the fraction width with round half up, then saturated.
	function automatic longint qmul(longint a, longint b);
		logic signed [127:0] wa, wb, p, hi_lim, lo_lim;
		wa = a;
		wb = b;
		hi_lim = SAT_HI;
		lo_lim = SAT_LO;
		p = (wa * wb + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (p > hi_lim) return SAT_HI;
		if (p < lo_lim) return SAT_LO;
		return longint'(p);
	endfunction

	function automatic longint lane_term(int l, longint vp, longint cp, longint vn,
			longint cn, longint d2raw, longint sk);
		longint is, iss, dc, adv, d2, disp;
		if (l >= lanes_on) return 0;
		is = step_inv;
		iss = step_inv_sq;
		dc = disp_coef[l];
		adv = qmul(qmul(vn, cn) - qmul(vp, cp), is);
		d2 = qmul(d2raw, iss);
		disp = qmul(dc, d2);
		return sat48(disp - adv - sk);
	endfunction

	function automatic void predict_node(node_t n);
		longint v, t;
		longint c[NUM_LANES];
		longint s[NUM_LANES];
		deriv_t r;
		v = sx48(n.vel);
		for (int l = 0; l < NUM_LANES; l++) begin
			c[l] = sx48(n.conc[l]);
			s[l] = sx48(n.sink[l]);
		end
		r = '0;
		if (hist_count == 0) begin
			r.kind = KIND_INLET;
			fresh_q.push_back(r);
		end else begin
			if (hist_count >= 2) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					t = lane_term(l, prev_vel, prev_conc[l], cur_vel, cur_conc[l],
						(c[l] - cur_conc[l]) - (cur_conc[l] - prev_conc[l]), cur_sink[l]);
					r.d[l] = t[W-1:0];
				end
				r.kind = KIND_INTERIOR;
				fresh_q.push_back(r);
			end
			if (n.last) begin
				for (int l = 0; l < NUM_LANES; l++) begin
					t = lane_term(l, cur_vel, cur_conc[l], v, c[l], cur_conc[l] - c[l], s[l]);
					r.d[l] = t[W-1:0];
				end
				r.kind = KIND_OUTLET;
				fresh_q.push_back(r);
			end
		end
		if (n.last) begin
			hist_count = 0;
		end else begin
			prev_vel = cur_vel;
			prev_conc = cur_conc;
			cur_vel = v;
			cur_conc = c;
			cur_sink = s;
			hist_count = (hist_count >= 2) ? 2 : hist_count + 1;
		end
		if (fresh_q.size() > 0) begin
			r = fresh_q.pop_back();
			r.fin = 1'b1;
			fresh_q.push_back(r);
		end
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
		if (idx == CFG_INV_STEP) step_inv = val;
		else if (idx == CFG_INV_STEP_SQ) step_inv_sq = val;
		else if (idx == CFG_ACTIVE) lanes_on = val[ACT_WIDTH-1:0];
		else if (idx >= CFG_DISP_BASE && idx < CFG_ACTIVE) disp_coef[idx - CFG_DISP_BASE] = val;
	endfunction

	always @(posedge clk) begin : observe
		deriv_t want;
		deriv_t inlet_zero;
		logic [NUM_LANES-1:0][W-1:0] got;
		node_taken_now = 1'b0;
		if (arst_n) begin
			if (cfg_write) apply_reg(cfg_index, cfg_data);
			if (node_valid && !node_stall) begin
				node_taken_now = 1'b1;
				nodes_in++;
				fresh_q.delete();
				predict_node(drive_node);
				if (row_typed) begin
					fresh_q.delete();
					inlet_zero = '0;
					inlet_zero.kind = KIND_INLET;
					inlet_zero.fin = 1'b1;
					for (int k = 0; k < row_typed_n; k++) fresh_q.push_back(inlet_zero);
				end
				foreach (fresh_q[k]) deriv_expected_q.push_back(fresh_q[k]);
			end
			if (deriv_valid && !deriv_stall) begin
				results_seen++;
				got = {deriv_comp3, deriv_comp2, deriv_comp1, deriv_comp0};
				if (deriv_expected_q.size() == 0) begin
					$error("unexpected derivative item, node_kind %0d", node_kind);
					err_count++;
				end else begin
					want = deriv_expected_q.pop_front();
					for (int l = 0; l < NUM_LANES; l++) begin
						if (got[l] !== want.d[l]) begin
							$error("deriv_comp%0d mismatch: expected %h, actual %h", l, want.d[l],
								got[l]);
							err_count++;
						end
					end
					if (node_kind !== want.kind) begin
						$error("node_kind mismatch: expected %0d, actual %0d", want.kind, node_kind);
						err_count++;
					end
					if (run_last !== want.fin) begin
						$error("run_last mismatch: expected %0d, actual %0d", want.fin, run_last);
						err_count++;
					end
					if (want.kind == KIND_OUTLET) outlets_seen++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_served) begin
			hold_served = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			deriv_stall <= 1'b1;
		end else begin
			deriv_stall <= ($urandom_range(0, 99) < rx_pct);
		end
	end

	function automatic logic [W-1:0] rand_data();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return r[W-1:0];
			4, 5, 6, 7: return {{(W-28){r[27]}}, r[27:0]};
			8: begin
				case ($urandom_range(0, 4))
					0: return MAX_Q;
					1: return MIN_Q;
					2: return '0;
					3: return W'(1);
					default: return '1;
				endcase
			end
			default: return ONE_Q + {{(W-8){r[7]}}, r[7:0]};
		endcase
	endfunction

	function automatic logic [CFG_WIDTH-1:0] rand_cfg();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return r[CFG_WIDTH-1:0];
			1, 2: return CFG_WIDTH'(r[25:0]);
			default: return r[CFG_WIDTH-1:0] >> $urandom_range(0, CFG_WIDTH - 1);
		endcase
	endfunction

	function automatic node_t random_node();
		node_t n;
		n.vel = rand_data();
		for (int l = 0; l < NUM_LANES; l++) begin
			n.conc[l] = rand_data();
			n.sink[l] = rand_data();
		end
		n.last = ($urandom_range(0, 4) == 0);
		return n;
	endfunction

	function automatic drow_t mk_row(logic [W-1:0] v, logic [W-1:0] c, logic [W-1:0] s,
			logic last, logic typed, logic [1:0] typed_n);
		drow_t r;
		r.node.vel = v;
		for (int l = 0; l < NUM_LANES; l++) begin
			r.node.conc[l] = c;
			r.node.sink[l] = s;
		end
		r.node.last = last;
		r.typed = typed;
		r.typed_n = typed_n;
		return r;
	endfunction

	task automatic send_node(node_t n, logic typed, logic [1:0] typed_n);
		while ($urandom_range(0, 99) < tx_pct) begin
			node_valid <= 1'b0;
			@(negedge clk);
		end
		node_valid <= 1'b1;
		drive_node <= n;
		row_typed <= typed;
		row_typed_n <= typed_n;
		do @(negedge clk); while (!node_taken_now);
	endtask

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_config(logic [CFG_WIDTH-1:0] is, logic [CFG_WIDTH-1:0] iss,
			logic [NUM_LANES-1:0][CFG_WIDTH-1:0] dc, logic [CFG_WIDTH-1:0] act);
		write_reg(CFG_INV_STEP, is);
		write_reg(CFG_INV_STEP_SQ, iss);
		for (int l = 0; l < NUM_LANES; l++) write_reg(CFG_IDX_WIDTH'(CFG_DISP_BASE + l), dc[l]);
		write_reg(CFG_ACTIVE, act);
		cfg_write <= 1'b0;
		@(negedge clk);
		settings_done++;
	endtask

	task automatic set_idle(int mode, bit hold);
		@(posedge clk);
		case (mode)
			1: begin tx_pct = 60; rx_pct = 0; end
			2: begin tx_pct = 0; rx_pct = 60; end
			3: begin tx_pct = 14; rx_pct = 14; end
			default: begin tx_pct = 0; rx_pct = 0; end
		endcase
		if (hold) hold_req++;
		@(negedge clk);
	endtask

	task automatic settle();
		node_valid <= 1'b0;
		while (deriv_expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [NUM_LANES-1:0][CFG_WIDTH-1:0] dc;
		logic [CFG_WIDTH-1:0] is, iss, act;
		dir_tab[0] = mk_row(MAX_Q, MAX_Q, MIN_Q, 1'b0, 1'b1, 2'd1);
		dir_tab[1] = mk_row(MIN_Q, MIN_Q, MAX_Q, 1'b0, 1'b1, 2'd0);
		dir_tab[2] = mk_row(MAX_Q, MAX_Q, MIN_Q, 1'b0, 1'b0, 2'd0);
		dir_tab[3] = mk_row(MIN_Q, '0, MAX_Q, 1'b1, 1'b0, 2'd0);
		dir_tab[4] = mk_row(ONE_Q, ONE_Q, ONE_Q, 1'b1, 1'b1, 2'd1);
		dir_tab[5] = mk_row('0, '0, '0, 1'b0, 1'b1, 2'd1);
		dir_tab[6] = mk_row(ONE_Q, ONE_Q << 1, -ONE_Q, 1'b1, 1'b0, 2'd0);
		dir_tab[7] = mk_row(ONE_Q, ONE_Q, '0, 1'b0, 1'b1, 2'd1);
		dir_tab[8] = mk_row(ONE_Q << 1, ONE_Q * 3, '0, 1'b0, 1'b1, 2'd0);
		dir_tab[9] = mk_row(ONE_Q, ONE_Q * 5, ONE_Q >> 1, 1'b0, 1'b0, 2'd0);
		dir_tab[10] = mk_row(-ONE_Q, -ONE_Q, W'(1), 1'b0, 1'b0, 2'd0);
		dir_tab[11] = mk_row(W'(1), '1, '0, 1'b1, 1'b0, 2'd0);
		dir_tab[12] = mk_row('1, '1, '1, 1'b0, 1'b1, 2'd1);
		dir_tab[13] = mk_row(W'(1), W'(1), W'(1), 1'b0, 1'b1, 2'd0);
		dir_tab[14] = mk_row('1, '0, '0, 1'b1, 1'b0, 2'd0);
		dir_tab[15] = mk_row(MIN_Q, MIN_Q, MIN_Q, 1'b1, 1'b1, 2'd1);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) send_node(dir_tab[i].node, dir_tab[i].typed, dir_tab[i].typed_n);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					is = CFG_MAX;
					iss = CFG_MAX;
					for (int l = 0; l < NUM_LANES; l++) dc[l] = CFG_MAX;
					act = CFG_WIDTH'(NUM_LANES);
				end
				3: begin
					is = '0;
					iss = '0;
					dc = '0;
					act = CFG_WIDTH'(1);
				end
				default: begin
					is = rand_cfg();
					iss = rand_cfg();
					for (int l = 0; l < NUM_LANES; l++) dc[l] = rand_cfg();
					act = CFG_WIDTH'((p % NUM_LANES) + 1);
				end
			endcase
			set_config(is, iss, dc, act);
			set_idle(p % 4, p == 4);
			repeat (PHASE_ITEMS) send_node(random_node(), 1'b0, 2'd0);
			settle();
		end

		$display("covered %0d nodes and %0d derivative items (%0d outlet items)",
			nodes_in, results_seen, outlets_seen);
		$display("over %0d register settings, four idle patterns and one long output hold-off",
			settings_done);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
